// ===== hdl/stbs_pkg.sv =====
// package for the sorted table binary search unit
// shared constants, command codes, controller states and command/status structs
// no dependencies
`default_nettype none

package stbs_pkg;

   localparam int TABLE_DEPTH_DEF = 256;
   localparam int KEY_W           = 32;
   localparam int INDEX_W         = 8;
   localparam int COUNT_W         = 9;
   localparam int POS_W           = 8;

   // item command codes
   localparam logic CMD_WRITE  = 1'b0;
   localparam logic CMD_SEARCH = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PROBE,
      ST_DONE
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic wr_en;     // store req_key at req_index
      logic start;     // capture key, load bounds, read first midpoint
      logic step;      // narrow bounds from compare, read next midpoint
      logic res_load;  // latch search outcome
      logic res_hit;   // outcome is a hit at current midpoint
      logic out_load;  // move outcome into output register
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic count_zero;  // no entries in use
      logic hit;         // probed entry equals sought key
      logic next_empty;  // bounds would meet or cross after this step
   } dp_status_type;

endpackage

`default_nettype wire

// ===== hdl/stbs_dpath.sv =====
// datapath of the sorted table binary search unit
// key table memory, search bounds, compare, result and output registers
// depends on stbs_pkg
`default_nettype none

module stbs_dpath #(
   parameter int TABLE_DEPTH = stbs_pkg::TABLE_DEPTH_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_valid,
   input  wire logic [stbs_pkg::COUNT_W-1:0]        csr_entry_count,
   input  wire logic [stbs_pkg::INDEX_W-1:0]        req_index,
   input  wire logic signed [stbs_pkg::KEY_W-1:0]   req_key,
   input  wire stbs_pkg::dp_cmd_type                dp_cmd,
   output stbs_pkg::dp_status_type                  dp_status,
   output logic                                     rsp_found,
   output logic [stbs_pkg::POS_W-1:0]               rsp_position
);

   localparam int AW    = $clog2(TABLE_DEPTH);
   localparam int CW    = $clog2(TABLE_DEPTH + 1);
   localparam int SW    = CW + 1;
   localparam int CMP_W = (CW > stbs_pkg::COUNT_W) ? CW : stbs_pkg::COUNT_W;

   logic [stbs_pkg::COUNT_W-1:0]      entry_count_ff, entry_count_in;
   logic signed [stbs_pkg::KEY_W-1:0] key_ff, key_in;
   logic [CW-1:0]                     lo_ff, lo_in, hi_ff, hi_in;
   logic [AW-1:0]                     mid_ff, mid_in;
   logic signed [stbs_pkg::KEY_W-1:0] rd_data_ff;
   logic signed [stbs_pkg::KEY_W-1:0] key_table_ff [TABLE_DEPTH];
   logic                              res_found_ff, res_found_in;
   logic [stbs_pkg::POS_W-1:0]        res_pos_ff, res_pos_in;
   logic                              rsp_found_ff, rsp_found_in;
   logic [stbs_pkg::POS_W-1:0]        rsp_pos_ff, rsp_pos_in;

   logic [CW-1:0] count_sat;
   logic [SW-1:0] sum_first, sum_next;
   logic [AW-1:0] mid_first, mid_next;
   logic [CW-1:0] mid_ext, lo_step, hi_step;
   logic          key_lt, key_eq;
   logic          wr_in_range;
   logic [AW-1:0] wr_addr;

   // count saturates at table depth
   always_comb begin
      if (CMP_W'(entry_count_ff) > CMP_W'(TABLE_DEPTH)) begin
         count_sat = CW'(TABLE_DEPTH);
      end else begin
         count_sat = CW'(entry_count_ff);
      end
   end

   // bounds: lo inclusive, hi exclusive
   always_comb begin
      sum_first = SW'(count_sat) - SW'(1);
      mid_first = AW'(sum_first >> 1);
      key_lt    = key_ff < rd_data_ff;
      key_eq    = key_ff == rd_data_ff;
      mid_ext   = CW'(mid_ff);
      if (key_lt) begin
         lo_step = lo_ff;
         hi_step = mid_ext;
      end else begin
         lo_step = CW'(mid_ext + CW'(1));
         hi_step = hi_ff;
      end
      sum_next = SW'(lo_step) + SW'(hi_step) - SW'(1);
      mid_next = AW'(sum_next >> 1);
   end

   always_comb begin
      dp_status.count_zero = (count_sat == '0);
      dp_status.hit        = key_eq;
      dp_status.next_empty = (lo_step >= hi_step);
   end

   always_comb begin
      entry_count_in = csr_valid ? csr_entry_count : entry_count_ff;
      key_in = key_ff;
      lo_in  = lo_ff;
      hi_in  = hi_ff;
      mid_in = mid_ff;
      if (dp_cmd.start) begin
         key_in = req_key;
         lo_in  = '0;
         hi_in  = count_sat;
         mid_in = mid_first;
      end else if (dp_cmd.step) begin
         lo_in  = lo_step;
         hi_in  = hi_step;
         mid_in = mid_next;
      end
   end

   always_comb begin
      res_found_in = res_found_ff;
      res_pos_in   = res_pos_ff;
      if (dp_cmd.res_load) begin
         res_found_in = dp_cmd.res_hit;
         res_pos_in   = dp_cmd.res_hit ? stbs_pkg::POS_W'(mid_ff) : '0;
      end
      rsp_found_in = dp_cmd.out_load ? res_found_ff : rsp_found_ff;
      rsp_pos_in   = dp_cmd.out_load ? res_pos_ff : rsp_pos_ff;
   end

   // writes beyond the table are dropped
   assign wr_in_range = (32'(req_index) < 32'(TABLE_DEPTH));
   assign wr_addr     = AW'(req_index);

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_count_ff <= '0;
      end else begin
         entry_count_ff <= entry_count_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff       <= key_in;
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      mid_ff       <= mid_in;
      res_found_ff <= res_found_in;
      res_pos_ff   <= res_pos_in;
      rsp_found_ff <= rsp_found_in;
      rsp_pos_ff   <= rsp_pos_in;
   end

   // key table, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (dp_cmd.wr_en && wr_in_range) begin
         key_table_ff[wr_addr] <= req_key;
      end
      rd_data_ff <= key_table_ff[mid_in];
   end

   assign rsp_found    = rsp_found_ff;
   assign rsp_position = rsp_pos_ff;

endmodule

`default_nettype wire

// ===== hdl/stbs_ctrl.sv =====
// controller of the sorted table binary search unit
// sequences writes, probes and result hand-off
// depends on stbs_pkg
`default_nettype none

module stbs_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   input  wire logic                    req_cmd,
   output logic                         req_ready,
   output logic                         rsp_valid,
   input  wire logic                    rsp_ready,
   output stbs_pkg::dp_cmd_type         dp_cmd,
   input  wire stbs_pkg::dp_status_type dp_status
);

   stbs_pkg::state_type state_ff, state_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                out_free;
   logic                is_search;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign is_search = (req_cmd == stbs_pkg::CMD_SEARCH);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         stbs_pkg::ST_IDLE: begin
            if (req_valid && is_search) begin
               state_in = dp_status.count_zero ? stbs_pkg::ST_DONE : stbs_pkg::ST_PROBE;
            end
         end
         stbs_pkg::ST_PROBE: begin
            if (dp_status.hit || dp_status.next_empty) begin
               state_in = stbs_pkg::ST_DONE;
            end
         end
         stbs_pkg::ST_DONE: begin
            if (out_free) begin
               state_in = stbs_pkg::ST_IDLE;
            end
         end
         default: state_in = stbs_pkg::ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      dp_cmd    = '0;
      req_ready = 1'b0;
      case (state_ff)
         stbs_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid && !is_search) begin
               dp_cmd.wr_en = 1'b1;
            end
            if (req_valid && is_search) begin
               dp_cmd.start    = 1'b1;
               dp_cmd.res_load = dp_status.count_zero;
            end
         end
         stbs_pkg::ST_PROBE: begin
            if (dp_status.hit) begin
               dp_cmd.res_load = 1'b1;
               dp_cmd.res_hit  = 1'b1;
            end else begin
               dp_cmd.step     = 1'b1;
               dp_cmd.res_load = dp_status.next_empty;
            end
         end
         stbs_pkg::ST_DONE: begin
            dp_cmd.out_load = out_free;
         end
         default: begin
            dp_cmd = '0;
         end
      endcase
   end

   always_comb begin
      if (dp_cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= stbs_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

// ===== hdl/sorted_table_binary_search_unit.sv =====
// write beat: taken with no response; writes stream one per cycle while idle
// search beat: probes one midpoint at a time through the single key table read
// port feeding the compare and bound update (floor(log2 n)+1 probes at most,
// 9 for 256 entries, none for an empty table); the result then waits for the
// output register to free up, and the next beat is taken the cycle after the move
// reset (synchronous, active high) clears control, response valid and entry_count
`default_nettype none

module sorted_table_binary_search_unit #(
   parameter int TABLE_DEPTH = stbs_pkg::TABLE_DEPTH_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // request channel
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic                              req_cmd,
   input  wire logic [stbs_pkg::INDEX_W-1:0]      req_index,
   input  wire logic signed [stbs_pkg::KEY_W-1:0] req_key,
   // response channel
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic                                   rsp_found,
   output logic [stbs_pkg::POS_W-1:0]             rsp_position,
   // entry_count register write
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [stbs_pkg::COUNT_W-1:0]      csr_entry_count
);

   stbs_pkg::dp_cmd_type    dp_cmd;
   stbs_pkg::dp_status_type dp_status;

   // register writes are always taken; software must write only while idle, the block does not enforce it
   assign csr_ready = 1'b1;

   // controller: idle takes beats, probe loops one midpoint per cycle,
   // done waits for the output register to free up
   stbs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_cmd   (req_cmd),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .dp_cmd    (dp_cmd),
      .dp_status (dp_status)
   );

   // datapath: key table, inclusive/exclusive bounds, signed compare,
   // result and output registers; unwritten table entries read as anything
   stbs_dpath #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .csr_valid       (csr_valid),
      .csr_entry_count (csr_entry_count),
      .req_index       (req_index),
      .req_key         (req_key),
      .dp_cmd          (dp_cmd),
      .dp_status       (dp_status),
      .rsp_found       (rsp_found),
      .rsp_position    (rsp_position)
   );

endmodule

`default_nettype wire
